// ===== rtl/lctp_pkg.sv =====
package lctp_pkg;

  // Default sizes of the mask memory and of the trace step budget
  localparam int DefMaxWidth  = 256;
  localparam int DefMaxHeight = 256;
  localparam int DefMaxSteps  = 65536;

  localparam int LabelW   = 16;
  localparam int DimW     = 9;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 16;
  localparam int CountW   = 17;
  localparam int PerimW   = 33;
  localparam int ProdW    = 2 * CountW;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] RegTarget = 2'd0;
  localparam logic [CfgAddrW-1:0] RegWidth  = 2'd1;
  localparam logic [CfgAddrW-1:0] RegHeight = 2'd2;

  localparam logic [LabelW-1:0] TargetReset = 16'd1;
  localparam logic [DimW-1:0]   WidthReset  = 9'd256;
  localparam logic [DimW-1:0]   HeightReset = 9'd256;

  localparam logic [CountW-1:0] CountCap = 17'd65536;
  localparam logic [CountW-1:0] AreaCap  = 17'h1FFFF;
  localparam logic [CountW-1:0] Sqrt2Q16 = 17'd92682;
  localparam logic [PerimW-1:0] PerimCap = 33'd6074007552;

  // Turn applied after a step: next search starts at (dir + 6) mod 8
  localparam logic [2:0] DirTurn  = 3'd6;
  localparam logic [2:0] DirFirst = 3'd0;
  localparam logic [2:0] DirLast  = 3'd7;

  typedef struct packed {
    logic [LabelW-1:0] pixel_label;
    logic              last_pixel;
  } pixel_t;

  typedef struct packed {
    logic              found;
    logic [7:0]        start_x;
    logic [7:0]        start_y;
    logic [CountW-1:0] region_area;
    logic [CountW-1:0] straight_steps;
    logic [CountW-1:0] diagonal_steps;
    logic [PerimW-1:0] perimeter_q16;
    logic              step_limit_hit;
  } result_t;

  typedef struct packed {
    logic load;
    logic init;
    logic probe;
    logic check;
    logic mul;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic start_seen;
    logic nb_hit;
    logic at_home;
    logic limit;
    logic last_dir;
  } dp_status_t;

  // Two's complement column offset of a direction, 0 = down-left, counterclockwise
  function automatic logic [1:0] dir_dx(input logic [2:0] d);
    logic [1:0] r;
    case (d)
      3'd0:    r = 2'b11;
      3'd1:    r = 2'b00;
      3'd2:    r = 2'b01;
      3'd3:    r = 2'b01;
      3'd4:    r = 2'b01;
      3'd5:    r = 2'b00;
      3'd6:    r = 2'b11;
      3'd7:    r = 2'b11;
      default: r = 2'b00;
    endcase
    return r;
  endfunction

  // Row offset of a direction; rows grow downward
  function automatic logic [1:0] dir_dy(input logic [2:0] d);
    logic [1:0] r;
    case (d)
      3'd0:    r = 2'b01;
      3'd1:    r = 2'b01;
      3'd2:    r = 2'b01;
      3'd3:    r = 2'b00;
      3'd4:    r = 2'b11;
      3'd5:    r = 2'b11;
      3'd6:    r = 2'b11;
      3'd7:    r = 2'b00;
      default: r = 2'b00;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/lctp_ctrl.sv =====
module lctp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  logic                  last_pixel_i,
  input  lctp_pkg::dp_status_t  status_i,
  output lctp_pkg::dp_cmd_t     cmd_o,
  output logic                  busy
);

  localparam logic [2:0] SLoad  = 3'd0;
  localparam logic [2:0] SInit  = 3'd1;
  localparam logic [2:0] SProbe = 3'd2;
  localparam logic [2:0] SCheck = 3'd3;
  localparam logic [2:0] SMul   = 3'd4;
  localparam logic [2:0] SEmit  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SLoad: begin
        cmd_o.load = start;
        if (start && last_pixel_i) begin
          state_d = SInit;
        end
      end
      SInit: begin
        cmd_o.init = 1'b1;
        state_d    = status_i.start_seen ? SProbe : SMul;
      end
      SProbe: begin
        cmd_o.probe = 1'b1;
        state_d     = SCheck;
      end
      SCheck: begin
        cmd_o.check = 1'b1;
        if (status_i.nb_hit) begin
          state_d = (status_i.at_home || status_i.limit) ? SMul : SProbe;
        end else begin
          state_d = status_i.last_dir ? SMul : SProbe;
        end
      end
      SMul: begin
        cmd_o.mul = 1'b1;
        state_d   = SEmit;
      end
      SEmit: begin
        cmd_o.emit = 1'b1;
        state_d    = SLoad;
      end
      default: begin
        state_d = SLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != SLoad);

endmodule

// ===== rtl/lctp_datapath.sv =====
module lctp_datapath #(
  parameter int MAX_WIDTH  = lctp_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = lctp_pkg::DefMaxHeight,
  parameter int MAX_STEPS  = lctp_pkg::DefMaxSteps
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lctp_pkg::dp_cmd_t               cmd_i,
  output lctp_pkg::dp_status_t            status_o,
  input  lctp_pkg::pixel_t                pixel_i,
  input  logic                            cfg_we_i,
  input  logic [lctp_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [lctp_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output logic                            done_o,
  output lctp_pkg::result_t               result_o
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int XW1   = XW + 1;
  localparam int YW1   = YW + 1;
  localparam int AW    = XW + YW;
  localparam int DEPTH = 2 ** AW;
  localparam int SW    = $clog2(MAX_STEPS + 1);
  localparam int CW    = lctp_pkg::CountW;

  // Configuration
  logic [lctp_pkg::LabelW-1:0] target_q;
  logic [lctp_pkg::DimW-1:0]   width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= lctp_pkg::TargetReset;
      width_q  <= lctp_pkg::WidthReset;
      height_q <= lctp_pkg::HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lctp_pkg::RegTarget: target_q <= cfg_wdata_i;
        lctp_pkg::RegWidth:  width_q  <= cfg_wdata_i[lctp_pkg::DimW-1:0];
        lctp_pkg::RegHeight: height_q <= cfg_wdata_i[lctp_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  // Effective image size: zero acts as one, clamp to the memory size
  logic [XW:0] eff_w;
  logic [YW:0] eff_h;

  always_comb begin
    if (width_q == '0) begin
      eff_w = XW1'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = XW1'(MAX_WIDTH);
    end else begin
      eff_w = XW1'(width_q);
    end
    if (height_q == '0) begin
      eff_h = YW1'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      eff_h = YW1'(MAX_HEIGHT);
    end else begin
      eff_h = YW1'(height_q);
    end
  end

  // Loading
  logic [XW-1:0] col_q, sx_q;
  logic [YW:0]   row_q;
  logic [YW-1:0] sy_q;
  logic [CW-1:0] area_q;
  logic          seen_q;
  logic          in_rows, in_cols, match, mem_we;
  logic [XW:0]   col_inc;

  assign in_rows = row_q < eff_h;
  assign in_cols = {1'b0, col_q} < eff_w;
  assign col_inc = {1'b0, col_q} + XW1'(1);
  assign match   = (pixel_i.pixel_label == target_q);
  assign mem_we  = cmd_i.load && in_rows && in_cols;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      area_q <= '0;
      seen_q <= 1'b0;
      sx_q   <= '0;
      sy_q   <= '0;
    end else if (cmd_i.emit) begin
      col_q  <= '0;
      row_q  <= '0;
      area_q <= '0;
      seen_q <= 1'b0;
    end else if (cmd_i.load && in_rows) begin
      if (in_cols && match) begin
        if (area_q != lctp_pkg::AreaCap) begin
          area_q <= area_q + CW'(1);
        end
        if (!seen_q) begin
          seen_q <= 1'b1;
          sx_q   <= col_q;
          sy_q   <= row_q[YW-1:0];
        end
      end
      if (col_inc >= eff_w) begin
        col_q <= '0;
        row_q <= row_q + YW1'(1);
      end else begin
        col_q <= col_inc[XW-1:0];
      end
    end
  end

  // Trace
  logic [XW-1:0] cx_q;
  logic [YW-1:0] cy_q;
  logic [2:0]    dir_q, k_q, dd_q;
  logic [SW-1:0] steps_q;
  logic [CW-1:0] str_q, dia_q;
  logic          hit_q, nvalid_q, rd_q;
  logic [XW:0]   nx_q;
  logic [YW:0]   ny_q;
  logic [2:0]    dd;
  logic [1:0]    dx, dy;
  logic [XW:0]   nx;
  logic [YW:0]   ny;
  logic          nvalid;
  logic [AW-1:0] raddr, waddr;

  assign dd = dir_q + k_q;
  assign dx = lctp_pkg::dir_dx(dd);
  assign dy = lctp_pkg::dir_dy(dd);
  assign nx = {1'b0, cx_q} + {{(XW - 1){dx[1]}}, dx};
  assign ny = {1'b0, cy_q} + {{(YW - 1){dy[1]}}, dy};
  // Off-image positions wrap to large values and fail the size compare
  assign nvalid = (nx < eff_w) && (ny < eff_h) &&
                  ((ny < row_q) || ((ny == row_q) && (nx < {1'b0, col_q})));
  assign raddr = {ny[YW-1:0], nx[XW-1:0]};
  assign waddr = {row_q[YW-1:0], col_q};

  logic mask_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mask_mem[waddr] <= match;
    end
    if (cmd_i.probe) begin
      rd_q <= mask_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe) begin
      nx_q     <= nx;
      ny_q     <= ny;
      dd_q     <= dd;
      nvalid_q <= nvalid;
    end
  end

  assign status_o.start_seen = seen_q;
  assign status_o.nb_hit     = nvalid_q && rd_q;
  assign status_o.at_home    = (nx_q[XW-1:0] == sx_q) && (ny_q[YW-1:0] == sy_q);
  assign status_o.limit      = (steps_q + SW'(1)) == SW'(MAX_STEPS);
  assign status_o.last_dir   = (k_q == lctp_pkg::DirLast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= '0;
      cy_q    <= '0;
      dir_q   <= lctp_pkg::DirFirst;
      k_q     <= '0;
      steps_q <= '0;
      str_q   <= '0;
      dia_q   <= '0;
      hit_q   <= 1'b0;
    end else if (cmd_i.init) begin
      cx_q    <= sx_q;
      cy_q    <= sy_q;
      dir_q   <= lctp_pkg::DirFirst;
      k_q     <= '0;
      steps_q <= '0;
      str_q   <= '0;
      dia_q   <= '0;
      hit_q   <= 1'b0;
    end else if (cmd_i.check) begin
      if (status_o.nb_hit) begin
        cx_q    <= nx_q[XW-1:0];
        cy_q    <= ny_q[YW-1:0];
        dir_q   <= dd_q + lctp_pkg::DirTurn;
        k_q     <= '0;
        steps_q <= steps_q + SW'(1);
        if (dd_q[0]) begin
          if (str_q != lctp_pkg::CountCap) str_q <= str_q + CW'(1);
        end else begin
          if (dia_q != lctp_pkg::CountCap) dia_q <= dia_q + CW'(1);
        end
        if (status_o.limit && !status_o.at_home) begin
          hit_q <= 1'b1;
        end
      end else begin
        k_q <= k_q + 3'd1;
      end
    end
  end

  // Perimeter: multiply, then add and saturate
  logic [lctp_pkg::ProdW-1:0] prod_q;
  logic [lctp_pkg::ProdW:0]   perim_sum;
  logic [lctp_pkg::PerimW-1:0] perim;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= {{CW{1'b0}}, dia_q} * {{CW{1'b0}}, lctp_pkg::Sqrt2Q16};
    end
  end

  assign perim_sum = {2'b00, str_q, 16'h0000} + {1'b0, prod_q};
  assign perim = (perim_sum > {2'b00, lctp_pkg::PerimCap}) ? lctp_pkg::PerimCap
                                                         : perim_sum[lctp_pkg::PerimW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_o.found          <= seen_q;
      result_o.start_x        <= seen_q ? 8'(sx_q) : 8'd0;
      result_o.start_y        <= seen_q ? 8'(sy_q) : 8'd0;
      result_o.region_area    <= area_q;
      result_o.straight_steps <= str_q;
      result_o.diagonal_steps <= dia_q;
      result_o.perimeter_q16  <= perim;
      result_o.step_limit_hit <= hit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.emit;
    end
  end

endmodule

// ===== rtl/label_contour_trace_perimeter.sv =====
// Contour tracer with perimeter measure. Pixels of a label image enter in raster
// order, one per cycle, each taken at a clock edge with start high and busy low;
// the block stores a one-bit match mask, counts the area and notes the first
// matching pixel. The pixel flagged last_pixel raises busy while the 8-neighbour
// contour is walked from that first pixel through the mask memory. Each candidate
// direction is a memory read followed by a decision, because the mask has a
// single read port; setup, multiply and result formatting come on top, and an
// image with no match skips the walk. The result is registered on result_o and
// marked by done_o, high for exactly one cycle; there is no back pressure, so
// sample it on that cycle. Configuration writes take effect at once and belong
// between images. The mask is not cleared: positions not yet loaded in the
// current image are never used.
module label_contour_trace_perimeter #(
  parameter int MAX_WIDTH  = lctp_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = lctp_pkg::DefMaxHeight,
  parameter int MAX_STEPS  = lctp_pkg::DefMaxSteps
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  lctp_pkg::pixel_t                pixel_i,
  input  logic                            cfg_we_i,
  input  logic [lctp_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [lctp_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output logic                            done_o,
  output lctp_pkg::result_t               result_o
);

  lctp_pkg::dp_cmd_t    cmd;
  lctp_pkg::dp_status_t status;

  // Sequence loading, neighbor probes and result formatting
  lctp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .last_pixel_i(pixel_i.last_pixel),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  // Hold the mask memory, counters, trace position and result register
  lctp_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_STEPS (MAX_STEPS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .pixel_i    (pixel_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  // A result strobe lasts one cycle
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // A result follows a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a trace");

  // An item that is not the last keeps the block ready
  a_load_stays_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !pixel_i.last_pixel) |=> !busy)
    else $error("busy raised by a non-final pixel");

  // The last item starts the trace
  a_last_starts_trace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && pixel_i.last_pixel) |=> busy)
    else $error("final pixel did not start the trace");

endmodule

// ===== test/tb_label_contour_trace_perimeter.sv =====
`timescale 1ns / 100ps

module tb_label_contour_trace_perimeter;
  import lctp_pkg::*;

  // Run the block at its default sizes so the predictor can share them
  localparam int MaxWidth   = DefMaxWidth;
  localparam int MaxHeight  = DefMaxHeight;
  localparam int MaxSteps   = DefMaxSteps;
  localparam int HalfPeriod = 5;
  localparam int MaxGap     = 12;
  // Idle cycles to let the block settle before a register write or the end
  localparam int SettleCycles = 16;
  // Allow a whole step-limited trace at the worst cost per step, four times over
  localparam int StallLimit = 4 * (MaxSteps * 16 + 64);
  localparam int RandomPixels   = 360;
  localparam int RandomContours = 12;
  // Index past the last register: writes there must be dropped
  localparam logic [CfgAddrW-1:0] RegUnused = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  pixel_t              pixel_i     = '0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i  = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                done_o;
  result_t             result_o;

  label_contour_trace_perimeter #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight),
    .MAX_STEPS (MaxSteps)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .pixel_i    (pixel_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  always begin
    #(HalfPeriod) clk_i = 1'b1;
    #(HalfPeriod) clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Contour predictor: a private copy of the registers, the match mask and the
  // load position, advanced once for every pixel item the block accepts.
  // ---------------------------------------------------------------------------
  logic [LabelW-1:0] tgt_label_q  = TargetReset;
  logic [DimW-1:0]   img_width_q  = WidthReset;
  logic [DimW-1:0]   img_height_q = HeightReset;
  bit                match_q [MaxWidth*MaxHeight];
  int                load_col_q;
  int                load_row_q;
  logic [CountW-1:0] area_q = '0;
  bit                seen_q;
  int                first_idx_q;
  // Column and row offsets, counterclockwise from down-left; rows grow downward
  int                step_dx [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};
  int                step_dy [8] = '{1, 1, 1, 0, -1, -1, -1, 0};

  result_t           contour_expected [$];
  int                mismatch_count;
  int                pixels_sent;
  int                cycle_count;
  int                last_activity;
  bit                gaps_on = 1'b1;

  // Treat 0 as 1 and clip anything past the memory size
  function automatic int clamp_dim(logic [DimW-1:0] v, int lim);
    if (v == 0) return 1;
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  // A neighbour counts only inside the image and among pixels already loaded
  function automatic bit mask_hit(int x, int y, int w, int h);
    if (x < 0 || y < 0 || x >= w || y >= h) return 1'b0;
    if (!(y < load_row_q || (y == load_row_q && x < load_col_q))) return 1'b0;
    return match_q[y*MaxWidth + x];
  endfunction

  function automatic void predict_contour(pixel_t p);
    int          w, h, cx, cy, x0, y0, dir, sel, dd, steps, n_str, n_dia;
    bit          tracing, hit;
    logic [63:0] perim;
    result_t     r;
    w = clamp_dim(img_width_q, MaxWidth);
    h = clamp_dim(img_height_q, MaxHeight);
    // Store the pixel unless the image is already full
    if (load_row_q < h) begin
      if (load_col_q < w) begin
        match_q[load_row_q*MaxWidth + load_col_q] = (p.pixel_label == tgt_label_q);
        if (p.pixel_label == tgt_label_q) begin
          if (area_q != AreaCap) area_q++;
          if (!seen_q) begin
            seen_q      = 1'b1;
            first_idx_q = load_row_q*MaxWidth + load_col_q;
          end
        end
      end
      load_col_q++;
      if (load_col_q >= w) begin
        load_col_q = 0;
        load_row_q++;
      end
    end
    if (!p.last_pixel) return;

    r     = '0;
    n_str = 0;
    n_dia = 0;
    hit   = 1'b0;
    if (seen_q) begin
      x0        = first_idx_q % MaxWidth;
      y0        = first_idx_q / MaxWidth;
      r.found   = 1'b1;
      r.start_x = 8'(x0);
      r.start_y = 8'(y0);
      cx        = x0;
      cy        = y0;
      dir       = int'(DirFirst);
      steps     = 0;
      tracing   = 1'b1;
      while (tracing) begin
        if (steps >= MaxSteps) begin
          hit     = 1'b1;
          tracing = 1'b0;
        end else begin
          // Search from the current direction round all eight neighbours
          sel = -1;
          for (int k = 0; k < 8 && sel < 0; k++) begin
            dd = (dir + k) % 8;
            if (mask_hit(cx + step_dx[dd], cy + step_dy[dd], w, h)) sel = dd;
          end
          if (sel < 0) begin
            tracing = 1'b0;
          end else begin
            cx += step_dx[sel];
            cy += step_dy[sel];
            steps++;
            if (sel % 2 == 1) n_str++;
            else n_dia++;
            dir = (sel + int'(DirTurn)) % 8;
            if (cx == x0 && cy == y0) tracing = 1'b0;
          end
        end
      end
    end
    if (n_str > int'(CountCap)) n_str = int'(CountCap);
    if (n_dia > int'(CountCap)) n_dia = int'(CountCap);
    perim = (64'(n_str) << 16) + 64'(n_dia) * 64'(Sqrt2Q16);
    if (perim > 64'(PerimCap)) perim = 64'(PerimCap);
    r.region_area    = area_q;
    r.straight_steps = CountW'(n_str);
    r.diagonal_steps = CountW'(n_dia);
    r.perimeter_q16  = perim[PerimW-1:0];
    r.step_limit_hit = hit;
    contour_expected = {contour_expected, r};
    // Rewind the load position for the next image
    load_col_q = 0;
    load_row_q = 0;
    area_q     = '0;
    seen_q     = 1'b0;
  endfunction

  // Pick a label that differs from the target
  function automatic logic [LabelW-1:0] other_label(logic [LabelW-1:0] tgt);
    logic [LabelW-1:0] v;
    v = LabelW'($urandom);
    if (v == tgt) v = ~tgt;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: each strobe pops the oldest expected contour.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      last_activity = cycle_count;
      if (contour_expected.size() == 0) begin
        $error("result strobe with no contour expected");
        mismatch_count++;
      end else begin
        want = contour_expected.pop_front();
        check_field("found", want.found, result_o.found);
        check_field("start_x", want.start_x, result_o.start_x);
        check_field("start_y", want.start_y, result_o.start_y);
        check_field("region_area", want.region_area, result_o.region_area);
        check_field("straight_steps", want.straight_steps, result_o.straight_steps);
        check_field("diagonal_steps", want.diagonal_steps, result_o.diagonal_steps);
        check_field("perimeter_q16", want.perimeter_q16, result_o.perimeter_q16);
        check_field("step_limit_hit", want.step_limit_hit, result_o.step_limit_hit);
      end
    end
  end

  // Count cycles; bail out when nothing has moved for far too long
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count - last_activity < StallLimit) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one pixel item: idle for a random gap, then hold start until busy is low.
  // Leave start high afterwards so a back-to-back item does not need start to fall and rise again.
  task automatic send_pixel(logic [LabelW-1:0] lbl, bit last);
    int     gap;
    pixel_t p;
    gap           = gaps_on ? int'($urandom_range(0, MaxGap)) : 0;
    p.pixel_label = lbl;
    p.last_pixel  = last;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    pixel_i <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_contour(p);
    pixels_sent++;
    last_activity = cycle_count;
  endtask

  // Send a whole image; flag its final pixel as last
  task automatic send_frame(logic [LabelW-1:0] labels [$]);
    foreach (labels[i]) send_pixel(labels[i], i == labels.size() - 1);
  endtask

  // Drop start and wait for every pending contour, then let the block settle
  task automatic drain();
    start <= 1'b0;
    while (contour_expected.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write one register and mirror it into the predictor; call only when idle
  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegTarget: tgt_label_q  = val[LabelW-1:0];
      RegWidth:  img_width_q  = val[DimW-1:0];
      RegHeight: img_height_q = val[DimW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: target 1 on a 256x256 image; stop short after five pixels so
  // the rows below the start are never loaded
  task automatic test_reset_values();
    logic [LabelW-1:0] frame [$];
    frame = {16'h0000, 16'h0001, 16'h0001, 16'h0000, 16'h0001};
    send_frame(frame);
    drain();
  endtask

  // Hand-built images on small grids
  task automatic test_special_frames();
    logic [LabelW-1:0] frame [$];
    // A write to the unused index must not disturb the target
    write_reg(RegUnused, 16'h0000);
    write_reg(RegTarget, 16'hFFFF);
    write_reg(RegWidth, 16'd3);
    write_reg(RegHeight, 16'd3);
    // No match at all, with a near miss in every bit but the lowest
    frame = {16'h0000, 16'hFFFE};
    send_frame(frame);
    // Isolated pixel in the middle of a 3x3 image: no step
    frame = {16'h0000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h8000,
             16'h0000, 16'h0000, 16'h0000};
    send_frame(frame);
    drain();
    // 2x2 image, then pixels past its end that must be dropped
    write_reg(RegWidth, 16'd2);
    write_reg(RegHeight, 16'd2);
    frame = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF};
    send_frame(frame);
    drain();
  endtask

  // Random images in phases: one setting per phase, a few images back to back
  task automatic test_random_frames();
    logic [LabelW-1:0] frame [$];
    logic [LabelW-1:0] tgt, lbl;
    logic [CfgDataW-1:0] wval, hval;
    int sent0, contours, w, h, n, kind, density;
    sent0    = pixels_sent;
    contours = 0;
    while (pixels_sent - sent0 < RandomPixels || contours < RandomContours) begin
      drain();
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       tgt = '0;
        1:       tgt = '1;
        default: tgt = LabelW'($urandom);
      endcase
      // Mostly small images; width or height 0 now and then
      wval = ($urandom_range(0, 9) == 0) ? 16'd0 : CfgDataW'($urandom_range(1, 10));
      hval = ($urandom_range(0, 9) == 0) ? 16'd0 : CfgDataW'($urandom_range(1, 10));
      write_reg(RegTarget, tgt);
      write_reg(RegWidth, wval);
      write_reg(RegHeight, hval);
      w = clamp_dim(wval[DimW-1:0], MaxWidth);
      h = clamp_dim(hval[DimW-1:0], MaxHeight);
      repeat ($urandom_range(1, 6)) begin
        kind    = $urandom_range(0, 9);
        density = $urandom_range(10, 95);
        // Mostly complete images; some cut short, some running past the end
        n = w * h;
        if (kind == 8) n = $urandom_range(1, w * h);
        if (kind == 9) n = w * h + int'($urandom_range(1, 8));
        frame.delete();
        repeat (n) begin
          if (int'($urandom_range(0, 99)) < density) lbl = tgt;
          else if ($urandom_range(0, 7) == 0) lbl = tgt ^ (16'd1 << $urandom_range(0, 15));
          else lbl = other_label(tgt);
          frame = {frame, lbl};
        end
        send_frame(frame);
        contours++;
        // Hold off now and then until the trace has reported
        if ($urandom_range(0, 7) == 0) drain();
      end
    end
    gaps_on = 1'b1;
    drain();
  endtask

  // Largest sizes: a full-width row and a full-height column, each with its only
  // match at the far end
  task automatic test_largest_frames();
    logic [LabelW-1:0] frame [$];
    // 0xFFFF wraps to 511 in the register and clips to the memory width
    write_reg(RegTarget, 16'hFFFF);
    write_reg(RegWidth, 16'hFFFF);
    write_reg(RegHeight, 16'd1);
    frame.delete();
    repeat (MaxWidth - 1) frame = {frame, other_label(16'hFFFF)};
    frame = {frame, 16'hFFFF};
    send_frame(frame);
    drain();
    write_reg(RegTarget, 16'h0000);
    write_reg(RegWidth, 16'd0);
    write_reg(RegHeight, 16'(MaxHeight));
    frame.delete();
    repeat (MaxHeight - 1) frame = {frame, other_label(16'h0000)};
    frame = {frame, 16'h0000};
    send_frame(frame);
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_special_frames();
    test_random_frames();
    test_largest_frames();
    drain();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
